/* hdl/mstp_pkg.sv */
// ----------------------------------------------------------------------------
// mstp_pkg - timer pool shared definitions
// Slot record, per-cell control group, operation and status codes.
// ----------------------------------------------------------------------------
package mstp_pkg;

   localparam int MAX_NAMED_SLOTS = 16;
   localparam int COUNT_W         = 32;

   // operation codes on req_mode
   localparam logic [1:0] MODE_TICK    = 2'd0;
   localparam logic [1:0] MODE_ALLOC   = 2'd1;
   localparam logic [1:0] MODE_RELEASE = 2'd2;

   // result codes on rsp_status
   localparam logic [2:0] ST_ALLOCATED = 3'd0;
   localparam logic [2:0] ST_EXPIRED   = 3'd1;
   localparam logic [2:0] ST_RELEASED  = 3'd2;
   localparam logic [2:0] ST_NO_EXPIRY = 3'd3;
   localparam logic [2:0] ST_FULL      = 3'd4;
   localparam logic [2:0] ST_NOT_USED  = 3'd5;

   typedef struct packed {
      logic               in_use;
      logic               periodic;
      logic [COUNT_W-1:0] remaining;
      logic [COUNT_W-1:0] reload_value;
   } slot_rec_type;

   typedef struct packed {
      logic shift;   // take the neighbour's record
      logic set;     // load a fresh allocation
      logic clr;     // free the slot
   } cell_ctl_type;

endpackage

/* hdl/mstp_cell.sv */
// ----------------------------------------------------------------------------
// mstp_cell - one timer slot of the ring
// Holds one slot record; loads it on allocate, frees it on release and
// passes it along the ring during a tick sweep.
// ----------------------------------------------------------------------------
module mstp_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  mstp_pkg::cell_ctl_type ctl,
   input  mstp_pkg::slot_rec_type shift_in,
   input  mstp_pkg::slot_rec_type set_rec,
   output mstp_pkg::slot_rec_type rec_out
);
   import mstp_pkg::*;

   slot_rec_type rec_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rec_ff.in_use <= 1'b0;
      end else begin
         priority if (ctl.set) begin
            rec_ff <= set_rec;
         end else if (ctl.clr) begin
            rec_ff.in_use <= 1'b0;
         end else if (ctl.shift) begin
            rec_ff <= shift_in;
         end else begin
            // nothing to do, keep the record
            rec_ff <= rec_ff;
         end
      end
   end

   assign rec_out = rec_ff;

endmodule

/* hdl/multi_slot_timer_pool.sv */
// ----------------------------------------------------------------------------
// multi_slot_timer_pool - pool of one-shot and periodic timer slots
// Allocate, release and tick operations over a ring of slot cells with one
// shared decrementer at the head of the ring.
// ----------------------------------------------------------------------------
// result: allocate and release give their result registered, in the cycle after the transfer
// tick: the sweep steps every slot through the single decrementer at the ring head,
//   then a finishing state; a step with an expiry and the finish wait for a free output
// throughput: one item at a time, a new transfer is taken once the pool is idle
// reset clears every in-use flag at once; no clearing pass is needed
// ----------------------------------------------------------------------------
module multi_slot_timer_pool #(
   parameter int SLOTS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_mode,
   input  logic        req_repeat_req,
   input  logic [31:0] req_period,
   input  logic [3:0]  req_slot,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [3:0]  rsp_slot_index,
   output logic        rsp_last
);
   import mstp_pkg::*;

   // only sixteen slots can be named by the 4-bit fields
   localparam int POOL  = (SLOTS < MAX_NAMED_SLOTS) ? SLOTS : MAX_NAMED_SLOTS;
   localparam int IDX_W = (POOL > 1) ? $clog2(POOL) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POOL - 1);

   // sequencer codes
   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SWEEP = 2'd1;
   localparam logic [1:0] S_FIN   = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [IDX_W-1:0] ptr_ff, ptr_in;
   logic             hold_valid_ff, hold_valid_in;
   logic [IDX_W-1:0] hold_idx_ff, hold_idx_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [2:0]       rsp_status_ff, rsp_status_in;
   logic [3:0]       rsp_slot_ff, rsp_slot_in;
   logic             rsp_last_ff, rsp_last_in;

   slot_rec_type rec   [POOL];
   cell_ctl_type ctl   [POOL];
   slot_rec_type set_rec;
   slot_rec_type head_next;

   logic             accept;
   logic             out_free;
   logic             push;
   logic             any_free;
   logic [IDX_W-1:0] free_idx;
   logic [IDX_W-1:0] rel_idx;
   logic             rel_ok;
   logic             head_active;
   logic [31:0]      head_dec;
   logic             head_expire;
   logic             step_ok;

   // output register frees up in the same cycle as its transfer
   assign out_free = !rsp_valid_ff || rsp_ready;

   // a tick may start while a result still waits; its sweep stalls on the output
   assign req_ready = (state_ff == S_IDLE) &&
                      (out_free || (req_mode != MODE_ALLOC && req_mode != MODE_RELEASE));
   assign accept    = req_valid && req_ready;

   // lowest free slot, cells are in slot order whenever the pool is idle
   always_comb begin
      any_free = 1'b0;
      free_idx = '0;
      for (int i = POOL - 1; i >= 0; i--) begin
         if (!rec[i].in_use) begin
            any_free = 1'b1;
            free_idx = IDX_W'(i);
         end
      end
   end

   assign rel_idx = req_slot[IDX_W-1:0];
   assign rel_ok  = ({1'b0, req_slot} < 5'(POOL)) && rec[rel_idx].in_use;

   assign set_rec.in_use       = 1'b1;
   assign set_rec.periodic     = req_repeat_req;
   assign set_rec.remaining    = req_period;
   assign set_rec.reload_value = req_period;

   // shared decrementer on the record at the head of the ring
   assign head_active = rec[0].in_use && (rec[0].remaining != '0);
   assign head_dec    = rec[0].remaining - 32'd1;
   assign head_expire = head_active && (head_dec == '0);

   always_comb begin
      head_next = rec[0];
      if (head_active) begin
         head_next.remaining = (head_expire && rec[0].periodic) ?
                               rec[0].reload_value : head_dec;
      end
   end

   // an expiry must first hand the held one on, which needs a free output
   assign step_ok = (state_ff == S_SWEEP) &&
                    !(head_expire && hold_valid_ff && !out_free);

   // per-cell control
   always_comb begin
      for (int i = 0; i < POOL; i++) begin
         ctl[i].shift = step_ok;
         ctl[i].set   = accept && (req_mode == MODE_ALLOC) && any_free &&
                        (free_idx == IDX_W'(i));
         ctl[i].clr   = accept && (req_mode == MODE_RELEASE) && rel_ok &&
                        (rel_idx == IDX_W'(i));
      end
   end

   // ring of slot cells, the head feeds the decrementer and the tail takes its result
   for (genvar g = 0; g < POOL; g++) begin : g_cell
      slot_rec_type nbr;
      if (g == POOL - 1) begin : g_tail
         assign nbr = head_next;
      end else begin : g_mid
         assign nbr = rec[g+1];
      end
      mstp_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl[g]),
         .shift_in (nbr),
         .set_rec  (set_rec),
         .rec_out  (rec[g])
      );
   end

   // sequencer and result selection
   always_comb begin
      state_in      = state_ff;
      ptr_in        = ptr_ff;
      hold_valid_in = hold_valid_ff;
      hold_idx_in   = hold_idx_ff;
      push          = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_last_in   = rsp_last_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_mode)
                  MODE_TICK: begin
                     state_in      = S_SWEEP;
                     ptr_in        = '0;
                     hold_valid_in = 1'b0;
                  end
                  MODE_ALLOC: begin
                     push          = 1'b1;
                     rsp_status_in = any_free ? ST_ALLOCATED : ST_FULL;
                     rsp_slot_in   = any_free ? 4'(free_idx) : 4'd0;
                     rsp_last_in   = 1'b1;
                  end
                  MODE_RELEASE: begin
                     push          = 1'b1;
                     rsp_status_in = rel_ok ? ST_RELEASED : ST_NOT_USED;
                     rsp_slot_in   = rel_ok ? req_slot : 4'd0;
                     rsp_last_in   = 1'b1;
                  end
                  default: begin
                     // unused operation: no result
                  end
               endcase
            end
         end
         S_SWEEP: begin
            if (step_ok) begin
               if (head_expire) begin
                  // the held expiry is not the final one
                  if (hold_valid_ff) begin
                     push          = 1'b1;
                     rsp_status_in = ST_EXPIRED;
                     rsp_slot_in   = 4'(hold_idx_ff);
                     rsp_last_in   = 1'b0;
                  end
                  hold_valid_in = 1'b1;
                  hold_idx_in   = ptr_ff;
               end
               if (ptr_ff == LAST_IDX) begin
                  ptr_in   = '0;
                  state_in = S_FIN;
               end else begin
                  ptr_in = ptr_ff + 1'b1;
               end
            end
         end
         S_FIN: begin
            if (out_free) begin
               push          = 1'b1;
               rsp_status_in = hold_valid_ff ? ST_EXPIRED : ST_NO_EXPIRY;
               rsp_slot_in   = hold_valid_ff ? 4'(hold_idx_ff) : 4'd0;
               rsp_last_in   = 1'b1;
               hold_valid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (push) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         ptr_ff        <= '0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         ptr_ff        <= ptr_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      hold_idx_ff   <= hold_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_slot_index = rsp_slot_ff;
   assign rsp_last       = rsp_last_ff;

   // a held expiry never survives into idle
   a_idle_no_hold : assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !hold_valid_ff)
      else $error("held expiry left over in idle");

   // the ring pointer only moves during a sweep, so cells sit in slot order otherwise
   a_ptr_home : assert property (@(posedge clock) disable iff (reset)
      state_ff != S_SWEEP |-> ptr_ff == '0)
      else $error("ring out of slot order outside a sweep");

   // an accepted tick always starts a sweep
   a_tick_sweeps : assert property (@(posedge clock) disable iff (reset)
      accept && req_mode == MODE_TICK |=> state_ff == S_SWEEP)
      else $error("tick transfer did not start a sweep");

   // allocate with a free slot is answered next cycle as allocated
   a_alloc_answer : assert property (@(posedge clock) disable iff (reset)
      accept && req_mode == MODE_ALLOC && any_free
      |=> rsp_valid && rsp_status == ST_ALLOCATED && rsp_last)
      else $error("allocate with a free slot not answered");

endmodule

/* verif/multi_slot_timer_pool_tb.sv */
// ----------------------------------------------------------------------------
// multi_slot_timer_pool_tb - self-checking bench for the timer slot pool
// Drives allocate, tick, release and unused requests with random idling on both
// channels. It keeps its own copy of the slot state to work out every result.
// Results are compared in order, field by field.
// ----------------------------------------------------------------------------
module multi_slot_timer_pool_tb;

   import mstp_pkg::*;

   localparam int HALF_PERIOD  = 6;
   localparam int RESET_CYCLES = 7;
   localparam int SLOTS        = 16;
   localparam int POOL         = (SLOTS < MAX_NAMED_SLOTS) ? SLOTS : MAX_NAMED_SLOTS;
   localparam int LIVE_ITEMS   = 470;
   localparam int MAX_REPORTS  = 200;

   // the one request code that the pool ignores
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   typedef struct packed {
      logic [1:0]         mode;
      logic               repeat_req;
      logic [COUNT_W-1:0] period;
      logic [3:0]         slot;
   } timer_req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [3:0] slot_index;
      logic       last;
   } timer_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_mode = MODE_TICK;
   logic        req_repeat_req = 1'b0;
   logic [31:0] req_period = '0;
   logic [3:0]  req_slot = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_status;
   logic [3:0]  rsp_slot_index;
   logic        rsp_last;

   // requests waiting for the driver, results waiting for the monitor
   timer_req_type pending_reqs[$];
   timer_rsp_type pool_results_due[$];

   // shadow copy of the slot state
   logic               slot_busy   [MAX_NAMED_SLOTS];
   logic [COUNT_W-1:0] slot_count  [MAX_NAMED_SLOTS];
   logic [COUNT_W-1:0] slot_reload [MAX_NAMED_SLOTS];
   logic               slot_repeat [MAX_NAMED_SLOTS];

   int            mismatch_count = 0;
   int            live_count = 0;
   timer_req_type on_bus;
   int unsigned   gap_left = 0;
   int unsigned   stall_left = 0;
   logic          driver_calm = 1'b0;
   logic          monitor_calm = 1'b0;

   multi_slot_timer_pool #(
      .SLOTS(SLOTS)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mode       (req_mode),
      .req_repeat_req (req_repeat_req),
      .req_period     (req_period),
      .req_slot       (req_slot),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_slot_index (rsp_slot_index),
      .rsp_last       (rsp_last)
   );

   always #HALF_PERIOD clock = ~clock;

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
         $display("mismatch at %0t: %s", $time, what);
      end
   endtask

   // mostly no gap, often a short one, now and then a long one
   function automatic int unsigned idle_span();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 30);
   endfunction

   // small periods so that slots expire often, with the odd extreme
   function automatic logic [COUNT_W-1:0] pick_period();
      int unsigned r;
      r = $urandom_range(0, 19);
      if (r == 0) begin
         return '0;
      end else if (r == 1) begin
         return '1;
      end else if (r == 2) begin
         return $urandom();
      end
      return $urandom_range(1, 6);
   endfunction

   function automatic timer_req_type make_req(input logic [1:0] mode, input logic rep,
                                              input logic [COUNT_W-1:0] per,
                                              input logic [3:0] sl);
      timer_req_type r;
      r.mode       = mode;
      r.repeat_req = rep;
      r.period     = per;
      r.slot       = sl;
      return r;
   endfunction

   // fields that the operation does not use are filled at random as well
   function automatic timer_req_type rand_req(input logic [1:0] mode);
      return make_req(mode, 1'($urandom_range(0, 1)), pick_period(),
                      4'($urandom_range(0, 15)));
   endfunction

   task automatic enqueue(input timer_req_type r);
      pending_reqs.push_back(r);
      if (r.mode != MODE_UNUSED) begin
         live_count++;
      end
   endtask

   // apply one accepted request to the shadow pool and queue its results
   task automatic advance_timer_pool(input timer_req_type r);
      timer_rsp_type outs [MAX_NAMED_SLOTS];
      int            n;
      int            free_slot;
      n = 0;
      free_slot = -1;
      case (r.mode)
         MODE_TICK: begin
            for (int i = 0; i < POOL; i++) begin
               if (slot_busy[i] && slot_count[i] != '0) begin
                  slot_count[i] = slot_count[i] - 1'b1;
                  if (slot_count[i] == '0) begin
                     outs[n] = '{status: ST_EXPIRED, slot_index: 4'(i), last: 1'b0};
                     n++;
                     if (slot_repeat[i]) begin
                        slot_count[i] = slot_reload[i];
                     end
                  end
               end
            end
            if (n == 0) begin
               outs[0] = '{status: ST_NO_EXPIRY, slot_index: 4'd0, last: 1'b0};
               n = 1;
            end
         end
         MODE_ALLOC: begin
            for (int i = POOL - 1; i >= 0; i--) begin
               if (!slot_busy[i]) begin
                  free_slot = i;
               end
            end
            if (free_slot >= 0) begin
               slot_busy[free_slot]   = 1'b1;
               slot_count[free_slot]  = r.period;
               slot_reload[free_slot] = r.period;
               slot_repeat[free_slot] = r.repeat_req;
               outs[0] = '{status: ST_ALLOCATED, slot_index: 4'(free_slot), last: 1'b0};
            end else begin
               outs[0] = '{status: ST_FULL, slot_index: 4'd0, last: 1'b0};
            end
            n = 1;
         end
         MODE_RELEASE: begin
            if (int'(r.slot) < POOL && slot_busy[r.slot]) begin
               slot_busy[r.slot] = 1'b0;
               outs[0] = '{status: ST_RELEASED, slot_index: r.slot, last: 1'b0};
            end else begin
               outs[0] = '{status: ST_NOT_USED, slot_index: 4'd0, last: 1'b0};
            end
            n = 1;
         end
         default: begin
            // unused code, nothing comes back
         end
      endcase
      if (n != 0) begin
         outs[n-1].last = 1'b1;
      end
      for (int k = 0; k < n; k++) begin
         pool_results_due.push_back(outs[k]);
      end
   endtask

   // driver: predict on each request transfer, then present the next request
   // once any gap has run out
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
         for (int i = 0; i < MAX_NAMED_SLOTS; i++) begin
            slot_busy[i]   = 1'b0;
            slot_count[i]  = '0;
            slot_reload[i] = '0;
            slot_repeat[i] = 1'b0;
         end
      end else begin
         if (req_valid && req_ready) begin
            advance_timer_pool(on_bus);
         end
         if (!req_valid || req_ready) begin
            if (gap_left != 0) begin
               gap_left = gap_left - 1;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
               on_bus = pending_reqs.pop_front();
               req_valid      <= 1'b1;
               req_mode       <= on_bus.mode;
               req_repeat_req <= on_bus.repeat_req;
               req_period     <= on_bus.period;
               req_slot       <= on_bus.slot;
               // now and then switch between runs of back-to-back requests and gapped ones
               if ($urandom_range(0, 24) == 0) begin
                  driver_calm = !driver_calm;
               end
               gap_left = driver_calm ? 0 : idle_span();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: check each result transfer against the oldest expectation and
   // stall the result side at random
   always @(posedge clock) begin
      timer_rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pool_results_due.size() == 0) begin
               report_mismatch($sformatf("result with nothing due: status %0d slot %0d last %0d",
                                         rsp_status, rsp_slot_index, rsp_last));
            end else begin
               want = pool_results_due.pop_front();
               if (rsp_status !== want.status) begin
                  report_mismatch($sformatf("status %0d, wanted %0d",
                                            rsp_status, want.status));
               end
               if (rsp_slot_index !== want.slot_index) begin
                  report_mismatch($sformatf("slot_index %0d, wanted %0d",
                                            rsp_slot_index, want.slot_index));
               end
               if (rsp_last !== want.last) begin
                  report_mismatch($sformatf("last %0d, wanted %0d", rsp_last, want.last));
               end
            end
         end
         if ($urandom_range(0, 59) == 0) begin
            monitor_calm = !monitor_calm;
         end
         if (stall_left != 0) begin
            stall_left = stall_left - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (!monitor_calm && $urandom_range(0, 3) == 0) begin
               stall_left = idle_span();
            end
         end
      end
   end

   initial begin
      int unsigned pick;
      // empty pool: tick with nothing due, release of free slots at both ends
      enqueue(make_req(MODE_TICK, 1'b1, '1, 4'd15));
      enqueue(make_req(MODE_RELEASE, 1'b0, '0, 4'd0));
      enqueue(make_req(MODE_RELEASE, 1'b1, '1, 4'd15));
      // period zero never counts, period one periodic fires on every tick,
      // a one-shot holds at zero, the largest period stays far off
      enqueue(make_req(MODE_ALLOC, 1'b0, '0, 4'd0));
      enqueue(make_req(MODE_ALLOC, 1'b1, 32'd1, 4'd0));
      enqueue(make_req(MODE_ALLOC, 1'b0, 32'd2, 4'd0));
      enqueue(make_req(MODE_ALLOC, 1'b1, '1, 4'd0));
      repeat (3) enqueue(make_req(MODE_TICK, 1'b0, '0, 4'd0));
      // release a held one-shot, then release it once more
      enqueue(make_req(MODE_RELEASE, 1'b0, '0, 4'd2));
      enqueue(make_req(MODE_RELEASE, 1'b0, '0, 4'd2));
      // unused code with every payload bit set
      enqueue(make_req(MODE_UNUSED, 1'b1, '1, 4'd15));
      // fill the pool with period-one periodic slots, overflow it, then a
      // tick that expires nearly every slot at once
      repeat (13) enqueue(make_req(MODE_ALLOC, 1'b1, 32'd1, 4'd0));
      enqueue(make_req(MODE_ALLOC, 1'b0, 32'd3, 4'd0));
      enqueue(make_req(MODE_TICK, 1'b0, '0, 4'd0));
      enqueue(make_req(MODE_RELEASE, 1'b0, '0, 4'd15));

      // random part in short runs of one kind, so that the pool fills,
      // counts down and drains again
      while (live_count < LIVE_ITEMS) begin
         pick = $urandom_range(0, 9);
         case (pick)
            0, 1, 2: repeat ($urandom_range(2, 8)) enqueue(rand_req(MODE_ALLOC));
            3, 4, 5: repeat ($urandom_range(1, 6)) enqueue(rand_req(MODE_TICK));
            6, 7:    repeat ($urandom_range(1, 5)) enqueue(rand_req(MODE_RELEASE));
            8:       enqueue(rand_req(2'($urandom_range(0, 2))));
            default: enqueue(rand_req(MODE_UNUSED));
         endcase
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      while (pending_reqs.size() != 0 || req_valid) @(posedge clock);
      while (pool_results_due.size() != 0) @(posedge clock);
      // a trailing ignored request or a stray result would show up here
      repeat (4 * (POOL + 1)) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // guard against a hung handshake
   initial begin
      #15_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
